// File: hw/rtl/dsmt_pkg.sv
// Shared constants, codes and types of the Doppler spectrum mean tracker.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dsmt_pkg;

    localparam int MAX_BINS  = 512;
    localparam int MIN_BINS  = 4;
    localparam int MAX_EVEN  = MAX_BINS - (MAX_BINS % 2);

    localparam int N_W       = $clog2(MAX_BINS + 1);
    localparam int HALF_W    = N_W - 1;
    localparam int CNT_W     = N_W;
    localparam int SUM_W     = 2 * N_W - 3;
    localparam int DEN_W     = CNT_W + HALF_W - 1;
    localparam int FRAC_W    = 15;
    localparam int NUM_W     = SUM_W + FRAC_W + 2;
    localparam int STEP_W    = $clog2(FRAC_W + 1);

    localparam int BIN_W     = 8;
    localparam int THR_W     = 9;
    localparam int PEAK_W    = 11;
    localparam int MEAN_W    = 16;
    localparam int S_W       = ((N_W > PEAK_W) ? N_W : PEAK_W) + 2;

    localparam int CFG_W     = (N_W > THR_W) ? N_W : THR_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [N_W-1:0]    FFT_SIZE_RST  = N_W'(256);
    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(51);
    localparam logic [FRAC_W-1:0] Q_MAX         = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FFT_SIZE  = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_LOAD,
        DV_STEP,
        DV_DONE
    } div_state_t;

    typedef struct packed {
        logic [SUM_W-1:0]  pos_sum;
        logic [CNT_W-1:0]  pos_count;
        logic [SUM_W-1:0]  neg_sum;
        logic [CNT_W-1:0]  neg_count;
        logic [HALF_W-1:0] half;
    } line_totals_t;

endpackage

`default_nettype wire

// File: hw/rtl/dsmt_if.sv
// Valid/ready channel interfaces: spectrum bins in, mean pairs out.
// Depends on dsmt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dsmt_bin_if;
    import dsmt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [BIN_W-1:0]         bin_value;
    logic signed [PEAK_W-1:0] pos_peak_bins;
    logic signed [PEAK_W-1:0] neg_peak_bins;

    modport source (output valid, bin_value, pos_peak_bins, neg_peak_bins, input ready);
    modport sink   (input valid, bin_value, pos_peak_bins, neg_peak_bins, output ready);
endinterface

interface dsmt_mean_if;
    import dsmt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] pos_mean;
    logic signed [MEAN_W-1:0] neg_mean;

    modport source (output valid, pos_mean, neg_mean, input ready);
    modport sink   (input valid, pos_mean, neg_mean, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dsmt_accum.sv
// Per-bin accumulator: qualifies each bin and keeps the sums and counts of both sides.
// Depends on dsmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsmt_accum (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [dsmt_pkg::BIN_W-1:0]       bin_value,
    input  logic signed [dsmt_pkg::PEAK_W-1:0] pos_peak_bins,
    input  logic signed [dsmt_pkg::PEAK_W-1:0] neg_peak_bins,
    input  logic [dsmt_pkg::N_W-1:0]         n_bins,
    input  logic [dsmt_pkg::THR_W-1:0]       threshold,
    output dsmt_pkg::line_totals_t           totals,
    output logic                             line_end
);
    import dsmt_pkg::*;

    logic [N_W-1:0]    idx_reg, idx_next;
    logic [N_W-1:0]    pos_lim_reg, pos_lim_next;
    logic [N_W-1:0]    neg_start_reg, neg_start_next;
    logic [SUM_W-1:0]  pos_sum_reg, pos_sum_next;
    logic [SUM_W-1:0]  neg_sum_reg, neg_sum_next;
    logic [CNT_W-1:0]  pos_cnt_reg, pos_cnt_next;
    logic [CNT_W-1:0]  neg_cnt_reg, neg_cnt_next;
    logic [HALF_W-1:0] half_reg;
    logic              line_end_reg;

    logic [HALF_W-1:0]   half;
    logic                first;
    logic                pass;
    logic                pos_hit;
    logic                neg_hit;
    logic                last;
    logic signed [S_W-1:0] pp_s, np_s, n_s, half_s, st_s;
    logic [N_W-1:0]      lim_new, start_new;
    logic [SUM_W-1:0]    pos_base, neg_base;
    logic [CNT_W-1:0]    pos_cbase, neg_cbase;

    assign half   = n_bins[N_W-1:1];
    assign first  = (idx_reg == '0);
    assign pp_s   = S_W'(pos_peak_bins);
    assign np_s   = S_W'(neg_peak_bins);
    assign n_s    = signed'({{(S_W-N_W){1'b0}}, n_bins});
    assign half_s = signed'({{(S_W-HALF_W){1'b0}}, half});
    assign st_s   = n_s + np_s - S_W'(1);

    always_comb
    begin
        if (pp_s < 0)
        begin
            lim_new = '0;
        end
        else if (pp_s > half_s)
        begin
            lim_new = N_W'(half) + N_W'(1);
        end
        else
        begin
            lim_new = pp_s[N_W-1:0] + N_W'(1);
        end

        // The start is held inside the negative half: at most N-1, above half.
        if (st_s > n_s - S_W'(1))
        begin
            start_new = n_bins - N_W'(1);
        end
        else if (st_s <= half_s)
        begin
            start_new = N_W'(half) + N_W'(1);
        end
        else
        begin
            start_new = st_s[N_W-1:0];
        end
    end

    always_comb
    begin
        pos_lim_next   = first ? lim_new : pos_lim_reg;
        neg_start_next = first ? start_new : neg_start_reg;
        pos_base       = first ? '0 : pos_sum_reg;
        neg_base       = first ? '0 : neg_sum_reg;
        pos_cbase      = first ? '0 : pos_cnt_reg;
        neg_cbase      = first ? '0 : neg_cnt_reg;

        pass    = ({1'b0, bin_value} > threshold);
        pos_hit = pass && (idx_reg < pos_lim_next);
        neg_hit = pass && (idx_reg >= neg_start_next) && (idx_reg < n_bins);

        pos_sum_next = pos_base + (pos_hit ? SUM_W'(idx_reg) : '0);
        pos_cnt_next = pos_cbase + (pos_hit ? CNT_W'(1) : '0);
        neg_sum_next = neg_base + (neg_hit ? SUM_W'(n_bins - idx_reg) : '0);
        neg_cnt_next = neg_cbase + (neg_hit ? CNT_W'(1) : '0);

        last     = ({1'b0, idx_reg} + (N_W+1)'(1)) >= {1'b0, n_bins};
        idx_next = last ? '0 : idx_reg + N_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pos_lim_reg   <= '0;
            neg_start_reg <= '0;
            pos_sum_reg   <= '0;
            neg_sum_reg   <= '0;
            pos_cnt_reg   <= '0;
            neg_cnt_reg   <= '0;
            line_end_reg  <= 1'b0;
        end
        else
        begin
            line_end_reg <= take && last;
            if (take)
            begin
                idx_reg       <= idx_next;
                pos_lim_reg   <= pos_lim_next;
                neg_start_reg <= neg_start_next;
                pos_sum_reg   <= pos_sum_next;
                neg_sum_reg   <= neg_sum_next;
                pos_cnt_reg   <= pos_cnt_next;
                neg_cnt_reg   <= neg_cnt_next;
            end
        end
    end

    // The half size that divides the means is the one in force at the last bin.
    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            half_reg <= half;
        end
    end

    assign totals.pos_sum   = pos_sum_reg;
    assign totals.pos_count = pos_cnt_reg;
    assign totals.neg_sum   = neg_sum_reg;
    assign totals.neg_count = neg_cnt_reg;
    assign totals.half      = half_reg;
    assign line_end         = line_end_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dsmt_divider.sv
// Shared multiply and restoring compare-subtract unit under a small sequencer.
// Turns both sides' sums and counts into rounded Q0.15 magnitudes. Depends on dsmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsmt_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        ack,
    input  dsmt_pkg::line_totals_t      totals,
    output logic                        idle,
    output logic                        done,
    output logic [dsmt_pkg::FRAC_W-1:0] pos_q,
    output logic [dsmt_pkg::FRAC_W-1:0] neg_q
);
    import dsmt_pkg::*;

    div_state_t        st_reg, st_next;
    logic              sel_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [STEP_W-1:0] k_reg;
    logic [FRAC_W-1:0] q_reg;
    logic              sat_reg;
    logic              zero_reg;
    logic [FRAC_W-1:0] pos_q_reg;
    logic [FRAC_W-1:0] neg_q_reg;

    logic [SUM_W-1:0]        sum_sel;
    logic [CNT_W-1:0]        cnt_sel;
    logic [CNT_W+HALF_W-1:0] prod;
    logic                    fits;
    logic [NUM_W-1:0]        diff;
    logic                    top_step;
    logic [FRAC_W-1:0]       q_step;
    logic                    sat_step;
    logic [FRAC_W-1:0]       side_res;

    assign sum_sel = sel_reg ? totals.neg_sum : totals.pos_sum;
    assign cnt_sel = sel_reg ? totals.neg_count : totals.pos_count;
    assign prod    = cnt_sel * totals.half;

    // q = (sum * 2^16 + den) / (2 * den); a set bit at weight 2^15 means saturation.
    assign fits     = (rem_reg >= dsh_reg);
    assign diff     = rem_reg - dsh_reg;
    assign top_step = (k_reg == STEP_W'(FRAC_W));
    assign q_step   = q_reg | ((fits && !top_step) ? (FRAC_W'(1) << k_reg) : '0);
    assign sat_step = sat_reg | (fits && top_step);
    assign side_res = zero_reg ? '0 : (sat_step ? Q_MAX : q_step);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    st_next = DV_MUL;
                end
            end
            DV_MUL:  st_next = DV_LOAD;
            DV_LOAD: st_next = DV_STEP;
            DV_STEP:
            begin
                if (k_reg == '0)
                begin
                    st_next = sel_reg ? DV_DONE : DV_MUL;
                end
            end
            DV_DONE:
            begin
                if (ack)
                begin
                    st_next = DV_IDLE;
                end
            end
            default: st_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        idle = 1'b0;
        done = 1'b0;
        case (st_reg)
            DV_IDLE: idle = 1'b1;
            DV_DONE: done = 1'b1;
            default:
            begin
                idle = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= DV_IDLE;
            sel_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == DV_IDLE)
            begin
                sel_reg <= 1'b0;
            end
            else if (st_reg == DV_STEP && k_reg == '0)
            begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            DV_MUL:
            begin
                den_reg <= prod[DEN_W-1:0];
            end
            DV_LOAD:
            begin
                rem_reg  <= NUM_W'({sum_sel, {(FRAC_W+1){1'b0}}}) + NUM_W'(den_reg);
                dsh_reg  <= NUM_W'({den_reg, {(FRAC_W+1){1'b0}}});
                k_reg    <= STEP_W'(FRAC_W);
                q_reg    <= '0;
                sat_reg  <= 1'b0;
                zero_reg <= (cnt_sel == '0);
            end
            DV_STEP:
            begin
                rem_reg <= fits ? diff : rem_reg;
                dsh_reg <= dsh_reg >> 1;
                k_reg   <= k_reg - STEP_W'(1);
                q_reg   <= q_step;
                sat_reg <= sat_step;
                if (k_reg == '0)
                begin
                    if (sel_reg)
                    begin
                        neg_q_reg <= side_res;
                    end
                    else
                    begin
                        pos_q_reg <= side_res;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pos_q = pos_q_reg;
    assign neg_q = neg_q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (st_reg == DV_IDLE))
        else $error("line end arrived while the divider was busy");

    a_second_side: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == DV_STEP && k_reg == '0 && !sel_reg) |=> (st_reg == DV_MUL && sel_reg))
        else $error("negative side did not follow the positive side");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == DV_DONE && !ack)
        |=> (st_reg == DV_DONE && $stable(pos_q_reg) && $stable(neg_q_reg)))
        else $error("finished means changed before hand-off");

endmodule

`default_nettype wire

// File: hw/rtl/doppler_spectrum_mean_trace_core.sv
// Top level of the Doppler spectrum mean tracker: configuration registers, bin
// accumulator, shared divider and output register. Depends on dsmt_pkg, dsmt_if,
// dsmt_accum and dsmt_divider.
//
//   Channel    Dir   Request carries
//   spectrum   in    bin_value, pos_peak_bins, neg_peak_bins (peaks used at bin 0)
//   means      out   pos_mean, neg_mean (Q1.15), one request per spectrum line
//   cfg        in    cfg_we, cfg_index, cfg_data (write only)
//
// Bins are taken one per cycle while the divider is idle. After the last bin of a line,
// spectrum.ready stays low while the line closes, each side runs in the shared divider
// (one multiply, one load and 16 compare-subtract steps) and the pair is handed over.
// The finished pair sits in the output register, so the next line is accepted while
// means is stalled; a second line end waits in the divider until that register frees.
// Reset gives fft_size 256, threshold 51 and an empty line.
`timescale 1ns / 1ps
`default_nettype none

module doppler_spectrum_mean_trace_core (
    input  logic                              clk,
    input  logic                              rst_n,
    dsmt_bin_if.sink                          spectrum,
    dsmt_mean_if.source                       means,
    input  logic                              cfg_we,
    input  logic [dsmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsmt_pkg::CFG_W-1:0]        cfg_data
);
    import dsmt_pkg::*;

    logic [N_W-1:0]    fft_size_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic              out_valid_reg;
    logic [MEAN_W-1:0] pos_mean_reg;
    logic [MEAN_W-1:0] neg_mean_reg;

    logic [N_W-1:0]    n_even;
    logic [N_W-1:0]    n_bins;
    logic              take;
    logic              line_end;
    logic              div_idle;
    logic              div_done;
    logic              ack;
    logic [FRAC_W-1:0] pos_q;
    logic [FRAC_W-1:0] neg_q;
    line_totals_t      totals;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_size_reg  <= FFT_SIZE_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FFT_SIZE:  fft_size_reg  <= cfg_data[N_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Odd sizes drop their low bit, then the size is held to the supported range.
    always_comb
    begin
        n_even = {fft_size_reg[N_W-1:1], 1'b0};
        if (n_even < N_W'(MIN_BINS))
        begin
            n_bins = N_W'(MIN_BINS);
        end
        else if (n_even > N_W'(MAX_BINS))
        begin
            n_bins = N_W'(MAX_EVEN);
        end
        else
        begin
            n_bins = n_even;
        end
    end

    assign spectrum.ready = div_idle && !line_end;
    assign take           = spectrum.valid && spectrum.ready;
    assign ack            = div_done && (!out_valid_reg || means.ready);

    dsmt_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .bin_value     (spectrum.bin_value),
        .pos_peak_bins (spectrum.pos_peak_bins),
        .neg_peak_bins (spectrum.neg_peak_bins),
        .n_bins        (n_bins),
        .threshold     (threshold_reg),
        .totals        (totals),
        .line_end      (line_end)
    );

    dsmt_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (line_end),
        .ack    (ack),
        .totals (totals),
        .idle   (div_idle),
        .done   (div_done),
        .pos_q  (pos_q),
        .neg_q  (neg_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (means.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack)
        begin
            pos_mean_reg <= {1'b0, pos_q};
            neg_mean_reg <= MEAN_W'(0) - {1'b0, neg_q};
        end
    end

    assign means.valid    = out_valid_reg;
    assign means.pos_mean = pos_mean_reg;
    assign means.neg_mean = neg_mean_reg;

endmodule

`default_nettype wire

// File: dv/doppler_spectrum_mean_trace_core_tb.sv
// Self-checking testbench for doppler_spectrum_mean_trace_core: a directed table,
// then random spectrum lines under several register settings and random back-pressure.
// Depends on dsmt_pkg, the channel interfaces in dsmt_if and the core itself.
`timescale 1ns / 1ps

module doppler_spectrum_mean_trace_core_tb;
    import dsmt_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 45;
    localparam int LONG_HOLD    = 300;
    localparam int ITEM_BUDGET  = 1250;
    localparam int MIN_LINES    = 60;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_LINES   = 6;

    typedef struct packed {
        logic signed [MEAN_W-1:0] pos_mean;
        logic signed [MEAN_W-1:0] neg_mean;
    } mean_pair_t;

    typedef enum {ROW_WRITE, ROW_BIN} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        cfg_reg_t                 reg_sel;
        int unsigned              value;
        logic [BIN_W-1:0]         bin_value;
        logic signed [PEAK_W-1:0] pos_peak;
        logic signed [PEAK_W-1:0] neg_peak;
        bit                       typed;
        mean_pair_t               typed_pair;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dsmt_bin_if  spectrum_ch();
    dsmt_mean_if means_ch();

    doppler_spectrum_mean_trace_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .spectrum  (spectrum_ch),
        .means     (means_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Line tracker state, mirrored from the register writes and accepted bins.
    logic [N_W-1:0]   cfg_fft_size;
    logic [THR_W-1:0] cfg_threshold;
    int               line_pos;
    int               pos_limit;
    int               neg_first;
    int               pos_total;
    int               neg_total;
    int               pos_hits;
    int               neg_hits;

    mean_pair_t  expected_means[$];
    stim_row_t   directed_rows[$];
    int          fail_count;
    int          items_sent;
    int          lines_done;
    int          gap_pct;
    bit          quiet;
    bit          hold_request;
    int unsigned cycle_count;

    always #6 clk = ~clk;

    function automatic int active_bins();
        int n;
        n = int'(cfg_fft_size) & ~1;
        if (n < MIN_BINS)
            n = MIN_BINS;
        if (n > MAX_BINS)
            n = MAX_EVEN;
        return n;
    endfunction

    // Mean over half size in Q1.15, rounded half away from zero, saturated.
    function automatic logic [MEAN_W-1:0] q15_ratio(int sum, int count, int half);
        longint den;
        longint q;
        if (count == 0)
            return '0;
        den = longint'(count) * half;
        q = (longint'(sum) * 65536 + den) / (2 * den);
        if (q > 32767)
            q = 32767;
        return MEAN_W'(q);
    endfunction

    function automatic void track_bin(input logic [BIN_W-1:0] bin_value,
                                      input logic signed [PEAK_W-1:0] pos_peak,
                                      input logic signed [PEAK_W-1:0] neg_peak,
                                      output bit line_done, output mean_pair_t pair);
        int  n;
        int  half;
        int  first;
        bit  above;
        n = active_bins();
        half = n / 2;
        above = (bin_value > cfg_threshold);
        if (line_pos == 0) begin
            if (pos_peak < 0)
                pos_limit = 0;
            else if (int'(pos_peak) > half)
                pos_limit = half + 1;
            else
                pos_limit = int'(pos_peak) + 1;
            first = n + int'(neg_peak) - 1;
            if (first > n - 1)
                first = n - 1;
            else if (first <= half)
                first = half + 1;
            neg_first = first;
            pos_total = 0;
            neg_total = 0;
            pos_hits = 0;
            neg_hits = 0;
        end
        if (above && line_pos < pos_limit) begin
            pos_total += line_pos;
            pos_hits++;
        end
        if (above && line_pos >= neg_first && line_pos < n) begin
            neg_total += n - line_pos;
            neg_hits++;
        end
        line_done = (line_pos + 1 >= n);
        pair.pos_mean = q15_ratio(pos_total, pos_hits, half);
        pair.neg_mean = MEAN_W'(0 - int'(q15_ratio(neg_total, neg_hits, half)));
        if (line_done)
            line_pos = 0;
        else
            line_pos++;
    endfunction

    function automatic void note_mismatch(string what, mean_pair_t want, mean_pair_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH %s at %0t: expected pos %0d neg %0d, got pos %0d neg %0d",
                     what, $realtime, want.pos_mean, want.neg_mean,
                     got.pos_mean, got.neg_mean);
    endfunction

    function automatic void add_write(cfg_reg_t sel, int unsigned value);
        stim_row_t row;
        row = '{kind: ROW_WRITE, reg_sel: sel, default: '0};
        row.value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_bin(int value, int pos_peak, int neg_peak);
        stim_row_t row;
        row = '{kind: ROW_BIN, reg_sel: REG_FFT_SIZE, default: '0};
        row.bin_value = BIN_W'(value);
        row.pos_peak = PEAK_W'(pos_peak);
        row.neg_peak = PEAK_W'(neg_peak);
        directed_rows.push_back(row);
    endfunction

    // Last bin of a line whose means are written down by hand.
    function automatic void add_last_bin(int value, int pos_want, int neg_want);
        add_bin(value, 0, 0);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].typed_pair.pos_mean = MEAN_W'(pos_want);
        directed_rows[$].typed_pair.neg_mean = MEAN_W'(neg_want);
    endfunction

    task automatic wait_drained();
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input int unsigned value);
        spectrum_ch.valid <= 1'b0;
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_FFT_SIZE)
            cfg_fft_size = N_W'(value);
        else
            cfg_threshold = THR_W'(value);
    endtask

    task automatic send_bin(input logic [BIN_W-1:0] value,
                            input logic signed [PEAK_W-1:0] pos_peak,
                            input logic signed [PEAK_W-1:0] neg_peak,
                            input bit use_typed, input mean_pair_t typed_pair,
                            output bit line_done);
        mean_pair_t predicted;
        spectrum_ch.valid <= 1'b1;
        spectrum_ch.bin_value <= value;
        spectrum_ch.pos_peak_bins <= pos_peak;
        spectrum_ch.neg_peak_bins <= neg_peak;
        do
            @(posedge clk);
        while (!spectrum_ch.ready);
        items_sent++;
        track_bin(value, pos_peak, neg_peak, line_done, predicted);
        if (line_done)
            expected_means.push_back(use_typed ? typed_pair : predicted);
        if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            spectrum_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_random_line();
        int                       half;
        int                       thr;
        int                       pass_pct;
        logic signed [PEAK_W-1:0] pos_peak;
        logic signed [PEAK_W-1:0] neg_peak;
        logic [BIN_W-1:0]         value;
        mean_pair_t               no_override;
        bit                       done;
        half = active_bins() / 2;
        thr = int'(cfg_threshold);
        pass_pct = $urandom_range(0, 100);
        no_override = '0;
        // Most peaks land near the clamping points of both sides.
        if ($urandom_range(0, 3) == 0) begin
            pos_peak = PEAK_W'(int'($urandom_range(0, 1024)) - 512);
            neg_peak = PEAK_W'(int'($urandom_range(0, 1024)) - 512);
        end else begin
            pos_peak = PEAK_W'(int'($urandom_range(0, half + 4)) - 2);
            neg_peak = PEAK_W'(int'($urandom_range(0, half + 3)) - (half + 2));
        end
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(0, 3) == 0)
                value = BIN_W'($urandom_range(0, 255));
            else if (thr < 255 && $urandom_range(0, 99) < pass_pct)
                value = BIN_W'($urandom_range(thr + 1, 255));
            else
                value = BIN_W'($urandom_range(0, (thr > 255) ? 255 : thr));
            send_bin(value, pos_peak, neg_peak, 1'b0, no_override, done);
            // Peaks after bin zero are ignored by the block.
            pos_peak = PEAK_W'(int'($urandom_range(0, 1024)) - 512);
            neg_peak = PEAK_W'(int'($urandom_range(0, 1024)) - 512);
        end
        lines_done++;
    endtask

    initial begin : sink_drive
        int unsigned stall_left;
        stall_left = 0;
        means_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                stall_left = LONG_HOLD;
                hold_request = 1'b0;
            end else if (stall_left == 0 && !quiet && gap_pct != 0
                         && $urandom_range(0, 99) < gap_pct)
                stall_left = $urandom_range(1, 16);
            if (stall_left != 0) begin
                means_ch.ready <= 1'b0;
                stall_left--;
            end else
                means_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : mean_check
        mean_pair_t got;
        mean_pair_t want;
        if (rst_n && means_ch.valid && means_ch.ready) begin
            got.pos_mean = means_ch.pos_mean;
            got.neg_mean = means_ch.neg_mean;
            if (expected_means.size() == 0)
                note_mismatch("result with none pending", '0, got);
            else begin
                want = expected_means.pop_front();
                if (got.pos_mean !== want.pos_mean || got.neg_mean !== want.neg_mean)
                    note_mismatch("mean pair", want, got);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_means.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        stim_row_t   row;
        bit          done;
        int          phase;
        int unsigned size_sel;
        int unsigned thr_sel;
        int          line_total;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FFT_SIZE;
        cfg_data = '0;
        spectrum_ch.valid = 1'b0;
        spectrum_ch.bin_value = '0;
        spectrum_ch.pos_peak_bins = '0;
        spectrum_ch.neg_peak_bins = '0;
        cfg_fft_size = FFT_SIZE_RST;
        cfg_threshold = THRESHOLD_RST;
        line_pos = 0;
        pos_limit = 0;
        neg_first = 0;
        pos_total = 0;
        neg_total = 0;
        pos_hits = 0;
        neg_hits = 0;
        fail_count = 0;
        items_sent = 0;
        lines_done = 0;
        gap_pct = 20;
        quiet = 1'b0;
        hold_request = 1'b0;
        cycle_count = 0;

        // Four-bin lines, half size 2: the first side covers bins 0..2, the second bin 3.
        add_write(REG_FFT_SIZE, 4);
        add_bin(255, 2, -2);
        add_bin(255, 0, 0);
        add_bin(255, 0, 0);
        add_last_bin(255, 16384, -16384);
        // A lone positive bin at index half is a mean of 1.0 and saturates.
        add_bin(0, 2, -512);
        add_bin(0, 0, 0);
        add_bin(255, 0, 0);
        add_last_bin(0, 32767, 0);
        // A negative positive peak leaves the positive side empty.
        add_bin(255, -512, -512);
        add_bin(255, 0, 0);
        add_bin(255, 0, 0);
        add_last_bin(255, 0, -16384);
        // Peaks beyond the line clamp to the ends of both sides.
        add_write(REG_THRESHOLD, 254);
        add_bin(254, 511, 511);
        add_bin(255, 0, 0);
        add_bin(255, 0, 0);
        add_last_bin(255, 24576, -16384);
        add_write(REG_THRESHOLD, 256);
        add_bin(255, 512, 512);
        add_bin(255, 0, 0);
        add_bin(255, 0, 0);
        add_last_bin(255, 0, 0);
        // Odd size, then a size of zero written in the middle of a line: the line
        // shrinks to four bins, so the next bin closes it.
        add_write(REG_FFT_SIZE, 7);
        add_write(REG_THRESHOLD, 0);
        add_bin(1, 3, -1);
        add_bin(1, 0, 0);
        add_bin(0, 0, 0);
        add_bin(1, 0, 0);
        add_write(REG_FFT_SIZE, 0);
        add_bin(1, 0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < directed_rows.size(); r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE)
                write_reg(row.reg_sel, row.value);
            else
                send_bin(row.bin_value, row.pos_peak, row.neg_peak, row.typed,
                         row.typed_pair, done);
        end

        phase = 0;
        while (items_sent < ITEM_BUDGET || lines_done < MIN_LINES) begin
            case (phase)
                2:       size_sel = 1023;
                3:       size_sel = $urandom_range(4, 8);
                6:       size_sel = 256;
                default: size_sel = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                                : $urandom_range(0, 24);
            endcase
            case ($urandom_range(0, 5))
                0:       thr_sel = 0;
                1:       thr_sel = 255;
                2:       thr_sel = 256;
                default: thr_sel = $urandom_range(0, 256);
            endcase
            write_reg(REG_FFT_SIZE, size_sel);
            write_reg(REG_THRESHOLD, thr_sel);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            // One phase keeps offering bins while the result side is held off, so the
            // block backs up all the way to its input.
            if (phase == 3) begin
                gap_pct = 0;
                hold_request = 1'b1;
            end
            if (items_sent + QUIET_ITEMS >= ITEM_BUDGET)
                quiet = 1'b1;
            line_total = (active_bins() >= 256) ? 1 : $urandom_range(2, 8);
            if (phase == 3)
                line_total = HOLD_LINES;
            repeat (line_total) send_random_line();
            phase++;
        end

        spectrum_ch.valid <= 1'b0;
        wait_drained();
        if (fail_count == 0 && expected_means.size() == 0)
            $display("All tests passed");
        else begin
            if (expected_means.size() != 0)
                $display("%0d expected results never arrived", expected_means.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
